FILE: rtl/indexed_array_table_engine_unit_macros.svh
// assertion macros for the indexed array table engine
`ifndef INDEXED_ARRAY_TABLE_ENGINE_UNIT_MACROS_SVH
`define INDEXED_ARRAY_TABLE_ENGINE_UNIT_MACROS_SVH

// property that holds at every clock edge out of reset
`define IATE_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define IATE_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define IATE_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/iate_pkg.sv
// shared types and constants for the indexed array table engine
package iate_pkg;

  localparam int DEPTH  = 16;
  localparam int ADDR_W = 4;
  localparam int CNT_W  = 5;
  localparam int DATA_W = 32;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DATA_W-1:0] word_t;

  localparam cnt_t DEPTH_CNT = CNT_W'(DEPTH);

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_WRITE  = 3'd2,
    CMD_INSERT = 3'd3,
    CMD_DELETE = 3'd4,
    CMD_SEARCH = 3'd5,
    CMD_DUMP   = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic    vld;
    status_t status;
    addr_t   index;
    word_t   data;
    logic    last;
  } res_t;

endpackage

FILE: rtl/iate_ram.sv
// generic single-write, single-read ram with registered read data
module iate_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/iate_seq.sv
// command sequencer: decode, shift loop and scan over the element ram
module iate_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [2:0]      cmd,
  input  iate_pkg::addr_t position,
  input  iate_pkg::word_t value,
  output logic            busy,
  output iate_pkg::cnt_t  count,
  output iate_pkg::res_t  res,
  output logic            we,
  output iate_pkg::addr_t waddr,
  output iate_pkg::word_t wdata,
  output iate_pkg::addr_t raddr,
  input  iate_pkg::word_t rdata
);
  import iate_pkg::*;

  state_t state, state_next;
  cnt_t   ptr, ptr_next;
  cnt_t   count_next;
  logic   pend, pend_next;
  addr_t  pend_idx, pend_idx_next;
  logic   rd_vld, rd_vld_next;
  addr_t  rd_idx, rd_idx_next;
  logic [2:0] cmd_r;
  addr_t  pos_r;
  word_t  val_r;
  cnt_t   pos_ext;
  logic   scan_last;

  assign busy    = (state != S_IDLE);
  assign pos_ext = {1'b0, pos_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      pend   <= 1'b0;
      rd_vld <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      pend   <= pend_next;
      rd_vld <= rd_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr      <= ptr_next;
    pend_idx <= pend_idx_next;
    rd_idx   <= rd_idx_next;
    if (start && !busy) begin
      cmd_r <= cmd;
      pos_r <= position;
      val_r <= value;
    end
  end

  always_comb begin
    state_next    = state;
    ptr_next      = ptr;
    count_next    = count;
    pend_next     = pend;
    pend_idx_next = pend_idx;
    rd_vld_next   = 1'b0;
    rd_idx_next   = ptr[ADDR_W-1:0];
    we            = 1'b0;
    waddr         = ptr[ADDR_W-1:0];
    wdata         = val_r;
    raddr         = ptr[ADDR_W-1:0];
    res           = '0;
    scan_last     = (({1'b0, rd_idx} + 1'b1) == count);

    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_DECODE;
        end
      end

      S_DECODE: begin
        state_next = S_IDLE;
        res.vld    = 1'b1;
        res.last   = 1'b1;
        res.status = ST_OK;
        case (cmd_r)
          CMD_CLEAR: begin
            count_next = '0;
          end
          CMD_APPEND: begin
            if (count == DEPTH_CNT) begin
              res.status = ST_FULL;
            end else begin
              we         = 1'b1;
              waddr      = count[ADDR_W-1:0];
              count_next = count + 1'b1;
            end
          end
          CMD_WRITE: begin
            if (pos_ext >= count) begin
              res.status = ST_BAD_POS;
            end else begin
              we    = 1'b1;
              waddr = pos_r;
            end
          end
          CMD_INSERT: begin
            if (count == DEPTH_CNT) begin
              res.status = ST_FULL;
            end else if (pos_ext > count) begin
              res.status = ST_BAD_POS;
            end else begin
              res.vld    = 1'b0;
              ptr_next   = count;
              state_next = S_SHIFT_RD;
            end
          end
          CMD_DELETE: begin
            if (pos_ext >= count) begin
              res.status = ST_BAD_POS;
            end else begin
              res.vld    = 1'b0;
              ptr_next   = pos_ext;
              state_next = S_SHIFT_RD;
            end
          end
          CMD_SEARCH, CMD_DUMP: begin
            if (count == '0) begin
              res.status = ST_EMPTY;
            end else begin
              res.vld    = 1'b0;
              ptr_next   = '0;
              pend_next  = 1'b0;
              state_next = S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end

      S_SHIFT_RD: begin
        if (cmd_r == CMD_INSERT) begin
          if (ptr == pos_ext) begin
            // hole is open, drop the new word in
            we         = 1'b1;
            waddr      = pos_r;
            count_next = count + 1'b1;
            res.vld    = 1'b1;
            res.last   = 1'b1;
            state_next = S_IDLE;
          end else begin
            raddr      = ptr[ADDR_W-1:0] - 1'b1;
            state_next = S_SHIFT_WR;
          end
        end else begin
          if ((ptr + 1'b1) >= count) begin
            count_next = count - 1'b1;
            res.vld    = 1'b1;
            res.last   = 1'b1;
            state_next = S_IDLE;
          end else begin
            raddr      = ptr[ADDR_W-1:0] + 1'b1;
            state_next = S_SHIFT_WR;
          end
        end
      end

      S_SHIFT_WR: begin
        we         = 1'b1;
        waddr      = ptr[ADDR_W-1:0];
        wdata      = rdata;
        ptr_next   = (cmd_r == CMD_INSERT) ? ptr - 1'b1 : ptr + 1'b1;
        state_next = S_SHIFT_RD;
      end

      S_SCAN: begin
        // reads issue in the cycle before their compare
        if (ptr < count) begin
          raddr       = ptr[ADDR_W-1:0];
          rd_vld_next = 1'b1;
          rd_idx_next = ptr[ADDR_W-1:0];
          ptr_next    = ptr + 1'b1;
        end
        if (rd_vld) begin
          if (cmd_r == CMD_DUMP) begin
            res.vld   = 1'b1;
            res.index = rd_idx;
            res.data  = rdata;
            res.last  = scan_last;
            if (scan_last) begin
              state_next = S_IDLE;
            end
          end else begin
            // a match is held back until we know whether it is the final one
            if (rdata == val_r) begin
              if (pend) begin
                res.vld   = 1'b1;
                res.index = pend_idx;
              end
              pend_next     = 1'b1;
              pend_idx_next = rd_idx;
            end
            if (scan_last) begin
              state_next = S_FINISH;
            end
          end
        end
      end

      S_FINISH: begin
        res.vld    = 1'b1;
        res.last   = 1'b1;
        state_next = S_IDLE;
        if (pend) begin
          res.index = pend_idx;
        end else begin
          res.status = ST_EMPTY;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/indexed_array_table_engine_unit.sv
// clear, append, overwrite and rejects: result strobe registered from the decode state
// insert and delete: each shifted element goes through a read state, then a write state
// dump and search read one element per cycle; search compares each against the value
// search holds each match back one compare to mark the final one, and ends in S_FINISH
// results come one per cycle at most, no stall; busy drops as the last result shows
// synchronous reset empties the table; stored words are undefined until written
`include "indexed_array_table_engine_unit_macros.svh"
module indexed_array_table_engine_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  logic [2:0]      cmd,
  input  iate_pkg::addr_t position,
  input  iate_pkg::word_t value,
  output logic            valid,
  output logic [1:0]      status,
  output iate_pkg::addr_t index,
  output iate_pkg::word_t data,
  output iate_pkg::cnt_t  count,
  output logic            last
);
  import iate_pkg::*;

  res_t  res;
  logic  we;
  addr_t waddr;
  word_t wdata;
  addr_t raddr;
  word_t rdata;

  iate_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .cmd      (cmd),
    .position (position),
    .value    (value),
    .busy     (busy),
    .count    (count),
    .res      (res),
    .we       (we),
    .waddr    (waddr),
    .wdata    (wdata),
    .raddr    (raddr),
    .rdata    (rdata)
  );

  iate_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // result register, lines up with the count update
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= res.vld;
    end
  end

  always_ff @(posedge clk) begin
    status <= res.status;
    index  <= res.index;
    data   <= res.data;
    last   <= res.last;
  end

  `IATE_ALWAYS(a_count_range, count <= DEPTH_CNT, "entry count above depth")
  `IATE_IMPL(a_miss_is_last, valid && status == ST_EMPTY, last, "miss result not last")
  `IATE_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `IATE_IMPL(a_count_with_result, !$stable(count), valid, "count moved without a result")

endmodule
